// ===== rtl/core/mpq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mpq_pkg
// Shared constants and types for the min priority queue.
// ---------------------------------------------------------------------------
package mpq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  localparam int OCC_W     = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                        ins;
    logic                        rem;
    logic signed [KEY_WIDTH-1:0] key_new;
  } cell_ctrl_t;

endpackage : mpq_pkg
`default_nettype wire

// ===== rtl/core/mpq_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted key row: keeps, takes the new key, or shifts.
// ---------------------------------------------------------------------------
module mpq_cell
  import mpq_pkg::*;
(
  input  wire                          clk,
  input  wire cell_ctrl_t              ctrl,
  input  wire                          used,
  input  wire signed [KEY_WIDTH-1:0]   key_left,
  input  wire                          grab_left,
  input  wire signed [KEY_WIDTH-1:0]   key_right,
  output logic signed [KEY_WIDTH-1:0]  key,
  output logic                         grab
);

  logic signed [KEY_WIDTH-1:0] key_next;

  // new key belongs at or before this slot
  assign grab = !used || (key > ctrl.key_new);

  always_comb begin
    key_next = key;
    if (ctrl.ins) begin
      if (grab) begin
        key_next = grab_left ? key_left : ctrl.key_new;
      end
    end else if (ctrl.rem) begin
      key_next = key_right;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule : mpq_cell
`default_nettype wire

// ===== rtl/core/min_priority_queue_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// min_priority_queue_top
// Bounded min priority queue of signed keys built as a sorted row of cells.
// ---------------------------------------------------------------------------
// Takes one request per clock: busy is never raised, so start may be held
// high every cycle. Each request returns exactly one result, strobed by done
// on the cycle after it was accepted; the whole row of cells updates
// together, with every cell comparing its key to the new key in parallel. The
// receiver cannot stall: each result is valid only in its done cycle and
// must be taken then. The smallest key always sits in the first cell.
// Insert when full and remove when empty leave the queue unchanged and
// report status full or empty with key_out zero.
module min_priority_queue_top
  import mpq_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire                          operation,
  input  wire signed [KEY_WIDTH-1:0]   key_in,
  output logic                         busy,
  output logic                         done,
  output logic signed [KEY_WIDTH-1:0]  key_out,
  output logic [1:0]                   status,
  output logic [OCC_W-1:0]             occupancy
);

  logic [COUNT_W-1:0]          count;
  logic [COUNT_W-1:0]          count_next;
  logic                        req;
  logic                        is_full;
  logic                        is_empty;
  logic [1:0]                  status_next;
  cell_ctrl_t                  ctrl;
  logic signed [KEY_WIDTH-1:0] cell_key  [CAPACITY];
  logic                        cell_grab [CAPACITY];

  assign busy     = 1'b0;
  assign req      = start && !busy;
  assign is_full  = (count == COUNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    ctrl.ins     = 1'b0;
    ctrl.rem     = 1'b0;
    ctrl.key_new = key_in;
    count_next   = count;
    status_next  = ST_INSERTED;
    if (operation == OP_INSERT) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        ctrl.ins    = req;
        count_next  = count + 1'b1;
        status_next = ST_INSERTED;
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        ctrl.rem    = req;
        count_next  = count - 1'b1;
        status_next = ST_REMOVED;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [COUNT_W-1:0] IDX = COUNT_W'(i);
    logic signed [KEY_WIDTH-1:0] left_key;
    logic                        left_grab;
    logic signed [KEY_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_key  = '0;
      assign left_grab = 1'b0;
    end else begin : g_mid
      assign left_key  = cell_key[i-1];
      assign left_grab = cell_grab[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    mpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .used      (IDX < count),
      .key_left  (left_key),
      .grab_left (left_grab),
      .key_right (right_key),
      .key       (cell_key[i]),
      .grab      (cell_grab[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= req;
      if (req) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req) begin
      status    <= status_next;
      occupancy <= OCC_W'(count_next);
      key_out   <= (status_next == ST_REMOVED) ? cell_key[0] : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("key count above capacity");

  a_done_follows_req : assert property (@(posedge clk) disable iff (rst)
    req |=> done)
    else $error("request without result strobe");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !req |=> $stable(count))
    else $error("count moved without a request");

  a_empty_result : assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (key_out == '0 && occupancy == '0))
    else $error("bad empty result");

  a_full_result : assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (occupancy == OCC_W'(CAPACITY)))
    else $error("bad full result");
`endif

endmodule : min_priority_queue_top
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for min_priority_queue_top. Drives insert and remove
// requests on the start/busy handshake, tracks the stored keys in a local
// queue model and checks each done-strobed result (key, status, occupancy)
// in order. Covers empty and full queues, key extremes, duplicate keys and
// long random mixes with random sender gaps.
// ---------------------------------------------------------------------------
module tb;
  import mpq_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [KEY_WIDTH-1:0] key;
    logic [1:0]                  status;
    logic [OCC_W-1:0]            occupancy;
  } queue_result_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        operation;
  logic signed [KEY_WIDTH-1:0] key_in;
  logic                        busy;
  logic                        done;
  logic signed [KEY_WIDTH-1:0] key_out;
  logic [1:0]                  status;
  logic [OCC_W-1:0]            occupancy;

  min_priority_queue_top uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .key_in    (key_in),
    .busy      (busy),
    .done      (done),
    .key_out   (key_out),
    .status    (status),
    .occupancy (occupancy)
  );

  // local copy of the queue contents
  logic signed [KEY_WIDTH-1:0] held_keys [CAPACITY];
  int                          held_count;
  queue_result_t               pending_results [$];

  bit idle_enabled;
  int errors;
  int cycles;
  int n_inserted, n_removed, n_full, n_empty, n_checked;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic queue_result_t apply_request(input logic op,
                                                  input logic signed [KEY_WIDTH-1:0] key);
    queue_result_t r;
    int best;
    r.key = '0;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        held_keys[held_count] = key;
        held_count++;
        r.status = ST_INSERTED;
        n_inserted++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        best = 0;
        for (int i = 1; i < held_count; i++)
          if (held_keys[i] < held_keys[best]) best = i;
        r.key = held_keys[best];
        held_count--;
        held_keys[best] = held_keys[held_count];
        r.status = ST_REMOVED;
        n_removed++;
      end
    end
    r.occupancy = OCC_W'(held_count);
    return r;
  endfunction

  function automatic logic signed [KEY_WIDTH-1:0] pick_key();
    case ($urandom_range(9))
      0: case ($urandom_range(4))
           0: return {1'b1, {(KEY_WIDTH-1){1'b0}}};
           1: return {1'b0, {(KEY_WIDTH-1){1'b1}}};
           2: return '0;
           3: return '1;
           default: return 1;
         endcase
      1, 2, 3: return KEY_WIDTH'($signed($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Drives one request from the falling edge until the block takes it.
  task automatic send_request(input logic op, input logic signed [KEY_WIDTH-1:0] key);
    bit taken;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      if (idle_enabled && $urandom_range(99) < 8) begin
        start     = 1'b0;
        operation = $urandom;
        key_in    = $urandom;
        @(posedge clk);
      end else begin
        start     = 1'b1;
        operation = op;
        key_in    = key;
        @(posedge clk);
        if (!busy) begin
          pending_results.push_back(apply_request(op, key));
          taken = 1;
        end
      end
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: key %0d status %0d occupancy %0d",
                             key_out, status, occupancy));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (key_out !== want.key || status !== want.status ||
            occupancy !== want.occupancy)
          note_error($sformatf(
            "mismatch #%0d: key %0d/%0d status %0d/%0d occupancy %0d/%0d (exp/got)",
            n_checked, want.key, key_out, want.status, status,
            want.occupancy, occupancy));
      end
    end
  end

  task automatic test_empty_queue();
    send_request(OP_REMOVE, {1'b0, {(KEY_WIDTH-1){1'b1}}});
    send_request(OP_REMOVE, {1'b1, {(KEY_WIDTH-1){1'b0}}});
  endtask

  task automatic test_key_extremes();
    send_request(OP_INSERT, {1'b0, {(KEY_WIDTH-1){1'b1}}});
    send_request(OP_INSERT, {1'b1, {(KEY_WIDTH-1){1'b0}}});
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '1);
    send_request(OP_INSERT, 1);
    send_request(OP_INSERT, -8);
    send_request(OP_INSERT, -8);
    send_request(OP_INSERT, {1'b1, {(KEY_WIDTH-2){1'b0}}, 1'b1});
    repeat (9) send_request(OP_REMOVE, '1);
  endtask

  // fill past capacity, then drain past empty
  task automatic test_full_queue();
    while (held_count < CAPACITY) send_request(OP_INSERT, pick_key());
    repeat (3) send_request(OP_INSERT, pick_key());
    send_request(OP_REMOVE, pick_key());
    send_request(OP_INSERT, pick_key());
    send_request(OP_INSERT, pick_key());
    while (held_count > 0) send_request(OP_REMOVE, pick_key());
    repeat (2) send_request(OP_REMOVE, pick_key());
  endtask

  task automatic test_random_mix(input int count);
    int insert_pct;
    insert_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0)
        case ($urandom_range(2))
          0: insert_pct = 25;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      idle_enabled = !(n >= 300 && n < 600);
      if (n == count / 2) wait_results_drained();
      if ($urandom_range(99) < insert_pct) send_request(OP_INSERT, pick_key());
      else send_request(OP_REMOVE, pick_key());
    end
    idle_enabled = 1;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_INSERT;
    key_in    = '0;
    held_count   = 0;
    idle_enabled = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_queue();
    test_key_extremes();
    test_full_queue();
    test_random_mix(1800);

    wait_results_drained();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));

    $display("checked %0d results: %0d inserts, %0d removes, %0d full, %0d empty",
             n_checked, n_inserted, n_removed, n_full, n_empty);
    $display("errors %0d, cycles %0d", errors, cycles);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_queue_top.sv
tb/sv/tb.sv
